>>> rtl/core/lfwd_pkg.sv
// lfwd_pkg: field widths shared by the least-loaded dispatch block
// no dependencies
package lfwd_pkg;

  // fixed transaction field widths
  localparam int AmountWidth = 16;
  localparam int ChosenWidth = 2;
  localparam int SortedWidth = 32;
  localparam int ReportCount = 4;

endpackage

>>> rtl/core/least_loaded_four_way_dispatch.sv
// least_loaded_four_way_dispatch: greedy least-loaded assignment over bins
// depends on lfwd_pkg
//
// path: stage 1 register, then result register; out_stall_i can hold a result in either
// throughput: one transaction per cycle while in_stall_o is low; the argmin tree plus the
//   saturating add on the bin totals closes the per-item loop combinationally
// reset: bin totals clear to zero and both pipeline stages empty
module least_loaded_four_way_dispatch #(
  parameter int BinCount   = 4,
  parameter int TotalWidth = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lfwd_pkg::AmountWidth-1:0]  amount_i,
  input  logic                              last_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lfwd_pkg::ChosenWidth-1:0]  chosen_bin_o,
  output logic                              totals_valid_o,
  output logic [lfwd_pkg::SortedWidth-1:0]  sorted_first_o,
  output logic [lfwd_pkg::SortedWidth-1:0]  sorted_second_o,
  output logic [lfwd_pkg::SortedWidth-1:0]  sorted_third_o,
  output logic [lfwd_pkg::SortedWidth-1:0]  sorted_fourth_o
);
  import lfwd_pkg::*;

  localparam int IdxWidth  = (BinCount > 1) ? $clog2(BinCount) : 1;
  localparam int TreeLeafs = 1 << IdxWidth;
  localparam int SumWidth  = ((TotalWidth > AmountWidth) ? TotalWidth : AmountWidth) + 1;
  localparam int ClipWidth = (TotalWidth > SortedWidth) ? TotalWidth : SortedWidth;

  typedef logic [BinCount-1:0][TotalWidth-1:0] totals_t;

  // handshake control
  logic s1_valid_q, out_valid_q;
  logic s1_ready, out_ready, in_acc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_acc     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  // running totals
  totals_t totals_q, totals_d, totals_new;

  // argmin tree, ties resolve to the lower index (left child)
  logic [TotalWidth-1:0] node_val [1:2*TreeLeafs-1];
  logic [IdxWidth-1:0]   node_idx [1:2*TreeLeafs-1];

  always_comb begin
    for (int l = 0; l < TreeLeafs; l++) begin
      if (l < BinCount) begin
        node_val[TreeLeafs + l] = totals_q[l];
      end else begin
        node_val[TreeLeafs + l] = '1;
      end
      node_idx[TreeLeafs + l] = IdxWidth'(l);
    end
    for (int n = TreeLeafs - 1; n >= 1; n--) begin
      if (node_val[2*n] <= node_val[2*n+1]) begin
        node_val[n] = node_val[2*n];
        node_idx[n] = node_idx[2*n];
      end else begin
        node_val[n] = node_val[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end
    end
  end

  // saturating add into the chosen bin
  logic [IdxWidth-1:0]   best_idx;
  logic [SumWidth-1:0]   sum_full;
  logic [TotalWidth-1:0] sum_sat;

  assign best_idx = node_idx[1];
  assign sum_full = SumWidth'(node_val[1]) + SumWidth'(amount_i);
  assign sum_sat  = (sum_full > SumWidth'({TotalWidth{1'b1}})) ? '1
                                                                : sum_full[TotalWidth-1:0];

  always_comb begin
    totals_new = totals_q;
    totals_new[best_idx] = sum_sat;
    totals_d = totals_q;
    if (in_acc) begin
      totals_d = last_item_i ? '0 : totals_new;
    end
  end

  // stage 1 payload: chosen bin and snapshot of the updated totals
  totals_t               s1_totals_q;
  logic [IdxWidth-1:0]   s1_bin_q;
  logic                  s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      totals_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      totals_q <= totals_d;
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_totals_q <= totals_new;
      s1_bin_q    <= best_idx;
      s1_last_q   <= last_item_i;
    end
  end

  // rank each total: count smaller ones, ties broken by bin index
  logic [IdxWidth:0]                          rank [BinCount];
  logic [ReportCount-1:0][SortedWidth-1:0]    sorted_d;
  logic [ClipWidth-1:0]                       clip_ext;
  logic [SortedWidth-1:0]                     clip_val;

  always_comb begin
    for (int i = 0; i < BinCount; i++) begin
      rank[i] = '0;
      for (int j = 0; j < BinCount; j++) begin
        if ((s1_totals_q[j] < s1_totals_q[i]) ||
            ((s1_totals_q[j] == s1_totals_q[i]) && (j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
    sorted_d = '0;
    clip_ext = '0;
    clip_val = '0;
    for (int i = 0; i < BinCount; i++) begin
      clip_ext = ClipWidth'(s1_totals_q[i]);
      clip_val = (clip_ext > ClipWidth'({SortedWidth{1'b1}})) ? '1
                                                             : clip_ext[SortedWidth-1:0];
      for (int k = 0; k < ReportCount; k++) begin
        if (s1_last_q && (rank[i] == (IdxWidth+1)'(k))) begin
          sorted_d[k] = sorted_d[k] | clip_val;
        end
      end
    end
  end

  // result register
  logic [ChosenWidth-1:0]                  out_bin_q;
  logic                                    out_last_q;
  logic [ReportCount-1:0][SortedWidth-1:0] out_sorted_q;

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_bin_q    <= ChosenWidth'(s1_bin_q);
      out_last_q   <= s1_last_q;
      out_sorted_q <= sorted_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_bin_o    = out_bin_q;
  assign totals_valid_o  = out_last_q;
  assign sorted_first_o  = out_sorted_q[0];
  assign sorted_second_o = out_sorted_q[1];
  assign sorted_third_o  = out_sorted_q[2];
  assign sorted_fourth_o = out_sorted_q[3];

  // a last transaction leaves every bin total cleared
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_item_i |=> totals_q == '0)
    else $error("bin totals not cleared after last transaction");

  // plain results carry no totals
  a_no_totals_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !totals_valid_o |->
      (sorted_first_o == '0) && (sorted_second_o == '0) &&
      (sorted_third_o == '0) && (sorted_fourth_o == '0))
    else $error("sorted totals nonzero on a plain result");

  // reported totals come out in ascending order
  a_sorted_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && totals_valid_o && (BinCount >= ReportCount) |->
      (sorted_first_o <= sorted_second_o) && (sorted_second_o <= sorted_third_o) &&
      (sorted_third_o <= sorted_fourth_o))
    else $error("reported totals out of order");

  // an accepted transaction with a free result side reaches the output next cycle
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_ready |=> out_valid_o)
    else $error("stage 1 transaction lost");

endmodule
